[rtl/ptts_pkg.sv]
// ----------------------------------------------------------------------------
// ptts_pkg: shared types and constants of the periodic task tick scheduler
// Opcodes, run modes, sequencer states and the layout of one slot word.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int PTTS_SLOTS = 8;
  localparam int WORD_W     = 32;
  localparam int MASK_W     = 8;
  localparam int NSLOT_W    = 3;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_CREATE = 3'd1,
    OP_PAUSE  = 3'd2,
    OP_RESUME = 3'd3,
    OP_KILL   = 3'd4,
    OP_QUERY  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    MODE_READY  = 2'd0,
    MODE_PAUSED = 2'd1,
    MODE_KILLED = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_QUERY,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] period;
    logic [WORD_W-1:0] delay;
    logic [WORD_W-1:0] runs;
  } slot_word_t;

  typedef struct packed {
    slot_word_t word;
    logic       fired;
  } slot_upd_t;

endpackage

[rtl/ptts_slot_alu.sv]
// ----------------------------------------------------------------------------
// ptts_slot_alu: per-slot tick update
// Fires a slot whose delay has run out (reload, count the run), otherwise
// counts the delay down. Shared by every slot visit of the tick sequencer.
// ----------------------------------------------------------------------------
module ptts_slot_alu (
  input  ptts_pkg::slot_word_t cur,
  output ptts_pkg::slot_upd_t  upd
);
  import ptts_pkg::*;

  logic zero;

  assign zero = (cur.delay == '0);

  always_comb begin
    upd.word.period = cur.period;
    upd.fired       = zero;
    if (zero) begin
      // period zero wraps to all ones
      upd.word.delay = cur.period - WORD_W'(1);
      upd.word.runs  = cur.runs + WORD_W'(1);
    end else begin
      upd.word.delay = cur.delay - WORD_W'(1);
      upd.word.runs  = cur.runs;
    end
  end

endmodule

[rtl/periodic_task_tick_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_unit: time-triggered task slot scheduler
// Slot table with tick, create, pause, resume, kill and query commands.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid in_ready opcode task_id period    | input
//           | first_delay                               |
//   out     | out_valid out_ready status fire_mask       | output
//           | run_count new_slot tick_count             |
//
// A tick visits one slot per cycle through the slot memory (read one slot
// ahead of the write-back, and the shared slot update unit); a query reads
// its slot through the memory; create, pause, resume, kill act on accept.
// One word is in work at a time.
// Reset clears created bits, modes, free pointer and tick counter at once;
// no clearing pass. A stalled output holds its word; the next input word is
// taken while it waits, and its result holds in the final state until free.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_unit #(
  parameter int SLOTS = ptts_pkg::PTTS_SLOTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   opcode,
  input  logic [2:0]                   task_id,
  input  logic [ptts_pkg::WORD_W-1:0]  period,
  input  logic [ptts_pkg::WORD_W-1:0]  first_delay,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         status,
  output logic [ptts_pkg::MASK_W-1:0]  fire_mask,
  output logic [ptts_pkg::WORD_W-1:0]  run_count,
  output logic [ptts_pkg::NSLOT_W-1:0] new_slot,
  output logic [ptts_pkg::WORD_W-1:0]  tick_count
);
  import ptts_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int ID_W   = 7;

  state_t state, state_next;

  logic [SLOTS-1:0] created;
  mode_t            mode [SLOTS];
  slot_word_t       mem [0:SLOTS-1];
  slot_word_t       rdata;

  logic [CNT_W-1:0]  next_free;
  logic [WORD_W-1:0] ticks;
  logic [CNT_W-1:0]  cnt;
  logic              wr_vld;
  logic [SLOT_W-1:0] wr_idx;

  logic              res_status;
  logic [MASK_W-1:0] res_fire;
  logic [WORD_W-1:0] res_runs;
  logic [NSLOT_W-1:0] res_slot;
  logic              res_ok;

  logic              acc;
  logic [ID_W-1:0]   id7;
  logic [SLOT_W-1:0] id_idx;
  logic              id_ok;
  logic [SLOT_W-1:0] nf_idx;
  logic              can_create;
  logic [SLOT_W-1:0] cnt_idx;
  logic [SLOT_W-1:0] raddr;
  logic [SLOT_W-1:0] waddr;
  slot_word_t        wdata;
  logic              we;
  logic              wr_active;
  logic              out_load;
  slot_upd_t         upd;
  logic [ID_W-1:0]   wr7;
  logic [MASK_W-1:0] fire_bit;

  ptts_slot_alu u_alu (
    .cur (rdata),
    .upd (upd)
  );

  assign id7        = ID_W'(task_id);
  assign id_idx     = id7[SLOT_W-1:0];
  assign id_ok      = (id7 < ID_W'(SLOTS)) && created[id_idx];
  assign nf_idx     = next_free[SLOT_W-1:0];
  assign can_create = (next_free < CNT_W'(SLOTS));
  assign cnt_idx    = cnt[SLOT_W-1:0];
  assign wr_active  = wr_vld && created[wr_idx] && (mode[wr_idx] == MODE_READY);
  assign wr7        = ID_W'(wr_idx);
  // slots at eight and above run without a mask bit
  assign fire_bit   = (wr7 < ID_W'(MASK_W)) ? (MASK_W'(1) << wr7[NSLOT_W-1:0]) : '0;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (opcode)
            OP_TICK:  state_next = S_TICK;
            OP_QUERY: state_next = S_QUERY;
            default:  state_next = S_FIN;
          endcase
        end
      end
      S_TICK: begin
        if (cnt == CNT_W'(SLOTS)) state_next = S_FIN;
      end
      S_QUERY: state_next = S_FIN;
      S_FIN: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    in_ready = (state == S_IDLE);
    acc      = in_valid && in_ready;
    out_load = (state == S_FIN) && (!out_valid || out_ready);
    raddr    = (state == S_IDLE) ? id_idx : cnt_idx;
    we       = 1'b0;
    waddr    = wr_idx;
    wdata    = upd.word;
    if (acc && (opcode == OP_CREATE) && can_create) begin
      we          = 1'b1;
      waddr       = nf_idx;
      wdata.period = period;
      wdata.delay  = first_delay;
      wdata.runs   = '0;
    end else if (wr_active) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      created   <= '0;
      next_free <= '0;
      ticks     <= '0;
      cnt       <= '0;
      wr_vld    <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < SLOTS; i++) mode[i] <= MODE_READY;
    end else begin
      state  <= state_next;
      wr_vld <= (state == S_TICK) && (cnt < CNT_W'(SLOTS));
      if (state == S_TICK) cnt <= cnt + CNT_W'(1);
      else cnt <= '0;
      if (acc) begin
        case (opcode)
          OP_TICK: ticks <= ticks + WORD_W'(1);
          OP_CREATE: begin
            if (can_create) begin
              created[nf_idx] <= 1'b1;
              mode[nf_idx]    <= MODE_READY;
              next_free       <= next_free + CNT_W'(1);
            end
          end
          OP_PAUSE:  if (id_ok) mode[id_idx] <= MODE_PAUSED;
          OP_RESUME: if (id_ok) mode[id_idx] <= MODE_READY;
          OP_KILL:   if (id_ok) mode[id_idx] <= MODE_KILLED;
          default: ;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // result staging and output word
  always_ff @(posedge clk) begin
    wr_idx <= cnt_idx;
    if (acc) begin
      res_status <= (opcode == OP_CREATE) && !can_create;
      res_fire   <= '0;
      res_runs   <= '0;
      res_slot   <= ((opcode == OP_CREATE) && can_create) ? NSLOT_W'(next_free) : '0;
      res_ok     <= id_ok;
    end else begin
      if (wr_active && upd.fired) res_fire <= res_fire | fire_bit;
      if (state == S_QUERY) res_runs <= res_ok ? rdata.runs : '0;
    end
    if (out_load) begin
      status     <= res_status;
      fire_mask  <= res_fire;
      run_count  <= res_runs;
      new_slot   <= res_slot;
      tick_count <= ticks;
    end
  end

  a_fail_full: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_status) |-> (next_free == CNT_W'(SLOTS)))
    else $error("create failed with free slots left");

  a_wr_in_tick: assert property (@(posedge clk) disable iff (rst)
    wr_vld |-> (state == S_TICK))
    else $error("slot write outside tick sequence");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    acc |=> (state != S_IDLE))
    else $error("sequencer stayed idle after accepting a word");

  a_slot_only_create: assert property (@(posedge clk) disable iff (rst)
    (out_load && (res_slot != '0)) |-> (!res_status && (res_fire == '0) && (res_runs == '0)))
    else $error("slot index reported with other result fields");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !out_ready) |=> (state == S_FIN))
    else $error("result dropped while output stalled");

endmodule

[bench/tb_periodic_task_tick_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// tb_periodic_task_tick_scheduler_unit: self-checking bench for the scheduler
// Drives tick, create, pause, resume, kill, query and spare words through
// the valid/ready input, predicts every result word from a private copy of
// the slot table and compares each accepted output word field by field.
// ----------------------------------------------------------------------------
module tb_periodic_task_tick_scheduler_unit;
  import ptts_pkg::*;

  localparam logic [2:0] OP_SPARE_A   = 3'd6;
  localparam logic [2:0] OP_SPARE_B   = 3'd7;
  localparam int         RANDOM_WORDS = 1625;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         IDLE_PCT     = 18;

  typedef struct packed {
    logic                status;
    logic [MASK_W-1:0]   fire;
    logic [WORD_W-1:0]   runs;
    logic [NSLOT_W-1:0]  slot;
    logic [WORD_W-1:0]   ticks;
  } sched_word_t;

  class tick_sched_board;
    bit                slot_live   [PTTS_SLOTS];
    mode_t             slot_state  [PTTS_SLOTS];
    bit   [WORD_W-1:0] slot_wait   [PTTS_SLOTS];
    bit   [WORD_W-1:0] slot_reload [PTTS_SLOTS];
    bit   [WORD_W-1:0] slot_fires  [PTTS_SLOTS];
    int                alloc_ptr;
    bit   [WORD_W-1:0] tick_total;
    sched_word_t       due_words[$];
    int                errors;

    function new();
      foreach (slot_live[i]) begin
        slot_live[i]   = 1'b0;
        slot_state[i]  = MODE_READY;
        slot_wait[i]   = '0;
        slot_reload[i] = '0;
        slot_fires[i]  = '0;
      end
      alloc_ptr  = 0;
      tick_total = '0;
      errors     = 0;
    endfunction

    // Advance the slot table by one accepted word and queue its result.
    function void note_word(logic [2:0] op, logic [2:0] id,
                            logic [WORD_W-1:0] per, logic [WORD_W-1:0] fd);
      sched_word_t w;
      bit          hit;
      int          i;
      w   = '0;
      hit = (id < PTTS_SLOTS) && slot_live[id];
      case (op)
        OP_TICK: begin
          for (i = 0; i < PTTS_SLOTS; i++) begin
            if (slot_live[i] && slot_state[i] == MODE_READY) begin
              if (slot_wait[i] == '0) begin
                // period zero reloads to all ones
                slot_wait[i]  = slot_reload[i] - 1;
                slot_fires[i] = slot_fires[i] + 1;
                if (i < MASK_W) w.fire[i] = 1'b1;
              end else begin
                slot_wait[i] = slot_wait[i] - 1;
              end
            end
          end
          tick_total = tick_total + 1;
        end
        OP_CREATE: begin
          if (alloc_ptr < PTTS_SLOTS) begin
            slot_live[alloc_ptr]   = 1'b1;
            slot_state[alloc_ptr]  = MODE_READY;
            slot_reload[alloc_ptr] = per;
            slot_wait[alloc_ptr]   = fd;
            w.slot                 = alloc_ptr[NSLOT_W-1:0];
            alloc_ptr++;
          end else begin
            w.status = 1'b1;
          end
        end
        OP_PAUSE:  if (hit) slot_state[id] = MODE_PAUSED;
        OP_RESUME: if (hit) slot_state[id] = MODE_READY;
        OP_KILL:   if (hit) slot_state[id] = MODE_KILLED;
        OP_QUERY:  if (hit) w.runs = slot_fires[id];
        default: ;
      endcase
      w.ticks = tick_total;
      due_words.push_back(w);
    endfunction

    function void compare(string what, logic [WORD_W-1:0] exp, logic [WORD_W-1:0] got);
      if (got !== exp) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp, got);
      end
    endfunction

    function void check_word(logic st, logic [MASK_W-1:0] fm, logic [WORD_W-1:0] rc,
                             logic [NSLOT_W-1:0] ns, logic [WORD_W-1:0] tc);
      sched_word_t w;
      if (due_words.size() == 0) begin
        errors++;
        $display("%0t: result word with no prediction waiting, actual status %0h fire %0h",
                 $time, st, fm);
        return;
      end
      w = due_words.pop_front();
      compare("status", WORD_W'(w.status), WORD_W'(st));
      compare("fire_mask", WORD_W'(w.fire), WORD_W'(fm));
      compare("run_count", w.runs, rc);
      compare("new_slot", WORD_W'(w.slot), WORD_W'(ns));
      compare("tick_count", w.ticks, tc);
    endfunction
  endclass

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [2:0]         opcode      = '0;
  logic [2:0]         task_id     = '0;
  logic [WORD_W-1:0]  period      = '0;
  logic [WORD_W-1:0]  first_delay = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic               status;
  logic [MASK_W-1:0]  fire_mask;
  logic [WORD_W-1:0]  run_count;
  logic [NSLOT_W-1:0] new_slot;
  logic [WORD_W-1:0]  tick_count;

  bit steady   = 1'b0;
  bit hold_req = 1'b0;

  tick_sched_board sched = new;

  periodic_task_tick_scheduler_unit #(.SLOTS(PTTS_SLOTS)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .task_id     (task_id),
    .period      (period),
    .first_delay (first_delay),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .fire_mask   (fire_mask),
    .run_count   (run_count),
    .new_slot    (new_slot),
    .tick_count  (tick_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Called just after a falling edge; returns just after a falling edge, once the word has been accepted.
  task automatic offer_word(input logic [2:0] op, input logic [2:0] id,
                            input logic [WORD_W-1:0] per, input logic [WORD_W-1:0] fd);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    task_id     <= id;
    period      <= per;
    first_delay <= fd;
    do @(posedge clk); while (!in_ready);
    sched.note_word(op, id, per, fd);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (sched.due_words.size() != 0);
  endtask

  initial begin
    int         n;
    int         pick;
    logic [2:0] op;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table: slot commands before the first create miss
    offer_word(OP_QUERY,  3'd7, $urandom, $urandom);
    offer_word(OP_PAUSE,  3'd2, $urandom, $urandom);
    offer_word(OP_RESUME, 3'd2, $urandom, $urandom);
    offer_word(OP_KILL,   3'd2, $urandom, $urandom);
    offer_word(OP_TICK,   3'd0, $urandom, $urandom);
    offer_word(OP_SPARE_A, 3'd5, $urandom, $urandom);
    offer_word(OP_SPARE_B, 3'd3, $urandom, $urandom);
    offer_word(OP_CREATE, 3'd0, 32'd1, 32'd0);
    offer_word(OP_CREATE, 3'd0, 32'd0, 32'd0);
    offer_word(OP_CREATE, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_word(OP_CREATE, 3'd0, 32'd3, 32'd2);
    offer_word(OP_TICK,   3'd0, $urandom, $urandom);
    offer_word(OP_TICK,   3'd0, $urandom, $urandom);
    offer_word(OP_PAUSE,  3'd0, $urandom, $urandom);
    offer_word(OP_TICK,   3'd0, $urandom, $urandom);
    offer_word(OP_KILL,   3'd3, $urandom, $urandom);
    offer_word(OP_TICK,   3'd0, $urandom, $urandom);
    offer_word(OP_RESUME, 3'd0, $urandom, $urandom);
    offer_word(OP_RESUME, 3'd3, $urandom, $urandom);
    offer_word(OP_CREATE, 3'd0, 32'd2, 32'd1);
    offer_word(OP_CREATE, 3'd0, 32'd5, 32'd0);
    offer_word(OP_CREATE, 3'd0, 32'd4, 32'd3);
    offer_word(OP_CREATE, 3'd0, $urandom_range(7, 1), $urandom_range(3));
    offer_word(OP_CREATE, 3'd0, $urandom, $urandom);
    offer_word(OP_QUERY,  3'd0, $urandom, $urandom);
    offer_word(OP_QUERY,  3'd1, $urandom, $urandom);

    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 400) hold_req = 1'b1;
      steady = (n >= 900 && n < 1200);
      if (n == 1300) drain_results();
      pick = $urandom_range(99);
      if (pick < 45)      op = OP_TICK;
      else if (pick < 60) op = OP_QUERY;
      else if (pick < 70) op = OP_PAUSE;
      else if (pick < 82) op = OP_RESUME;
      else if (pick < 88) op = OP_KILL;
      else if (pick < 95) op = OP_CREATE;
      else if (pick < 98) op = OP_SPARE_A;
      else                op = OP_SPARE_B;
      offer_word(op, 3'($urandom_range(7)), $urandom, $urandom);
    end
    in_valid <= 1'b0;

    while (sched.due_words.size() != 0) @(posedge clk);
    repeat (PTTS_SLOTS + 8) @(posedge clk);
    if (sched.errors == 0 && sched.due_words.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Output side: random stalls, one long hold so the input backs up.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sched.check_word(status, fire_mask, run_count, new_slot, tick_count);
  end

  initial begin
    #800000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
